### hw/rtl/vcfc_pkg.sv
package vcfc_pkg;

    // Chunk geometry.
    localparam int SIDE_XZ = 16;
    localparam int HEIGHT  = 64;

    localparam int XW  = $clog2(SIDE_XZ);
    localparam int YW  = $clog2(HEIGHT);
    localparam int VAW = 2 * XW + YW;
    localparam int BAW = 2 + YW + XW;
    localparam int VOX_DEPTH = 2 ** VAW;
    localparam int BRD_DEPTH = 2 ** BAW;

    localparam logic [XW-1:0] XZ_MAX = XW'(SIDE_XZ - 1);
    localparam logic [YW-1:0] Y_MAX  = YW'(HEIGHT - 1);

    // Port field widths.
    localparam int ACT_W    = 2;
    localparam int POS_XZ_W = 4;
    localparam int POS_Y_W  = 6;
    localparam int BLK_W    = 16;
    localparam int BSIDE_W  = 2;
    localparam int SIDE_W   = 3;
    localparam int IDX_W    = 17;
    localparam int NP_W     = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_NEIGHBOR_PRESENT = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_VOXEL  = 2'd0,
        ACT_LOAD_BORDER = 2'd1,
        ACT_SCAN        = 2'd2
    } t_action;

    typedef enum logic [BSIDE_W-1:0] {
        BRD_NORTH = 2'd0,
        BRD_SOUTH = 2'd1,
        BRD_WEST  = 2'd2,
        BRD_EAST  = 2'd3
    } t_border;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_SOUTH = 3'd0,
        SIDE_EAST  = 3'd1,
        SIDE_NORTH = 3'd2,
        SIDE_WEST  = 3'd3,
        SIDE_UP    = 3'd4,
        SIDE_DOWN  = 3'd5
    } t_side;

    typedef enum logic [1:0] {
        NBR_OPEN   = 2'd0,
        NBR_VOXEL  = 2'd1,
        NBR_BORDER = 2'd2
    } t_nbr_kind;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CENTER = 2'd1,
        ST_SIDE   = 2'd2,
        ST_FIN    = 2'd3
    } t_state;

    typedef struct packed {
        logic  wr_voxel;
        logic  wr_border;
        logic  rd_center;
        t_side rd_side;
        logic  latch_center;
        logic  eval;
        t_side side;
        logic  finish;
    } t_cmd;

    typedef struct packed {
        logic center_empty;
    } t_status;

endpackage

### hw/rtl/vcfc_ctrl.sv
module vcfc_ctrl import vcfc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ACT_W-1:0]   i_action,
    input  t_status            i_status,
    output logic               o_busy,
    output t_cmd               o_cmd
);

    t_state r_state;
    t_state n_state;
    t_side  r_side;
    t_side  n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_side  <= SIDE_SOUTH;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
        end
    end

    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        case (r_state)
            ST_IDLE: begin
                if (i_start && (i_action == ACT_SCAN)) begin
                    n_state = ST_CENTER;
                end
            end
            ST_CENTER: begin
                n_side  = SIDE_SOUTH;
                n_state = i_status.center_empty ? ST_FIN : ST_SIDE;
            end
            ST_SIDE: begin
                if (r_side == SIDE_DOWN) begin
                    n_state = ST_FIN;
                end else begin
                    n_side = t_side'(r_side + 3'd1);
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.rd_center = 1'b1;
                if (i_start) begin
                    case (i_action)
                        ACT_LOAD_VOXEL:  o_cmd.wr_voxel  = 1'b1;
                        ACT_LOAD_BORDER: o_cmd.wr_border = 1'b1;
                        default:         o_cmd.wr_voxel  = 1'b0;
                    endcase
                end
            end
            ST_CENTER: begin
                o_cmd.latch_center = 1'b1;
                o_cmd.rd_side      = SIDE_SOUTH;
            end
            ST_SIDE: begin
                o_cmd.eval    = 1'b1;
                o_cmd.side    = r_side;
                o_cmd.rd_side = (r_side == SIDE_DOWN) ? SIDE_DOWN : t_side'(r_side + 3'd1);
            end
            ST_FIN: begin
                o_cmd.finish    = 1'b1;
                o_cmd.rd_center = 1'b1;
            end
            default: begin
                o_cmd.rd_center = 1'b1;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### hw/rtl/vcfc_datapath.sv
module vcfc_datapath import vcfc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [NP_W-1:0]     i_neighbor_present,
    input  logic [POS_XZ_W-1:0] i_pos_x,
    input  logic [POS_Y_W-1:0]  i_pos_y,
    input  logic [POS_XZ_W-1:0] i_pos_z,
    input  logic [BLK_W-1:0]    i_block_id,
    input  logic [BSIDE_W-1:0]  i_border_side,
    output logic                o_strobe,
    output logic                o_face_valid,
    output logic [POS_XZ_W-1:0] o_face_x,
    output logic [POS_Y_W-1:0]  o_face_y,
    output logic [POS_XZ_W-1:0] o_face_z,
    output logic [SIDE_W-1:0]   o_face_side,
    output logic [BLK_W-1:0]    o_face_block,
    output logic [IDX_W-1:0]    o_face_index,
    output logic                o_voxel_last,
    output logic                o_chunk_done
);

    typedef struct packed {
        t_nbr_kind      kind;
        logic [VAW-1:0] vaddr;
        logic [BAW-1:0] baddr;
    } t_nbr;

    // Where the neighbor across one face lives: in the chunk, in a border
    // plane, or nowhere (face always open).
    function automatic t_nbr nbr_of(t_side s, logic [XW-1:0] x, logic [YW-1:0] y,
                                    logic [XW-1:0] z, logic [NP_W-1:0] np);
        t_nbr r;
        r.kind  = NBR_VOXEL;
        r.vaddr = {x, y, z};
        r.baddr = {BRD_NORTH, y, x};
        case (s)
            SIDE_SOUTH: begin
                if (z == '0) begin
                    r.baddr = {BRD_SOUTH, y, x};
                    r.kind  = np[BRD_SOUTH] ? NBR_BORDER : NBR_OPEN;
                end else begin
                    r.vaddr = {x, y, XW'(z - 1'b1)};
                end
            end
            SIDE_EAST: begin
                if (x == XZ_MAX) begin
                    r.baddr = {BRD_EAST, y, z};
                    r.kind  = np[BRD_EAST] ? NBR_BORDER : NBR_OPEN;
                end else begin
                    r.vaddr = {XW'(x + 1'b1), y, z};
                end
            end
            SIDE_NORTH: begin
                if (z == XZ_MAX) begin
                    r.baddr = {BRD_NORTH, y, x};
                    r.kind  = np[BRD_NORTH] ? NBR_BORDER : NBR_OPEN;
                end else begin
                    r.vaddr = {x, y, XW'(z + 1'b1)};
                end
            end
            SIDE_WEST: begin
                if (x == '0) begin
                    r.baddr = {BRD_WEST, y, z};
                    r.kind  = np[BRD_WEST] ? NBR_BORDER : NBR_OPEN;
                end else begin
                    r.vaddr = {XW'(x - 1'b1), y, z};
                end
            end
            SIDE_UP: begin
                if (y == Y_MAX) begin
                    r.kind = NBR_OPEN;
                end else begin
                    r.vaddr = {x, YW'(y + 1'b1), z};
                end
            end
            SIDE_DOWN: begin
                if (y == '0) begin
                    r.kind = NBR_OPEN;
                end else begin
                    r.vaddr = {x, YW'(y - 1'b1), z};
                end
            end
            default: begin
                r.kind = NBR_OPEN;
            end
        endcase
        return r;
    endfunction

    logic [BLK_W-1:0] r_vox_mem [VOX_DEPTH];
    logic             r_brd_mem [BRD_DEPTH];
    logic [BLK_W-1:0] r_vox_rd;
    logic             r_brd_rd;

    logic [XW-1:0]    r_cur_x, n_cur_x;
    logic [YW-1:0]    r_cur_y, n_cur_y;
    logic [XW-1:0]    r_cur_z, n_cur_z;
    logic [IDX_W-1:0] r_face_total, n_face_total;
    logic             r_pend_valid, n_pend_valid;
    t_side            r_pend_side, n_pend_side;
    logic [IDX_W-1:0] r_pend_index, n_pend_index;
    logic [BLK_W-1:0] r_blk;

    logic             r_strobe;
    logic             r_face_valid;
    logic [XW-1:0]    r_face_x;
    logic [YW-1:0]    r_face_y;
    logic [XW-1:0]    r_face_z;
    t_side            r_face_side;
    logic [BLK_W-1:0] r_face_block;
    logic [IDX_W-1:0] r_face_index;
    logic             r_voxel_last;
    logic             r_chunk_done;

    t_nbr             w_rd_nbr;
    t_nbr             w_ev_nbr;
    logic [VAW-1:0]   w_vox_raddr;
    logic [VAW-1:0]   w_vox_waddr;
    logic [BAW-1:0]   w_brd_waddr;
    logic [POS_XZ_W-1:0] w_along;
    logic             w_vox_in_range;
    logic             w_brd_in_range;
    logic             w_vis;
    logic             w_done;
    logic             w_emit;
    logic             w_emit_valid;
    t_side            w_emit_side;
    logic [IDX_W-1:0] w_emit_index;
    logic             w_emit_last;

    // Load addressing; coordinates outside the chunk are dropped.
    assign w_along        = (i_border_side == BRD_NORTH || i_border_side == BRD_SOUTH)
                            ? i_pos_x : i_pos_z;
    assign w_vox_in_range = (32'(i_pos_x) < SIDE_XZ) && (32'(i_pos_y) < HEIGHT)
                            && (32'(i_pos_z) < SIDE_XZ);
    assign w_brd_in_range = (32'(i_pos_y) < HEIGHT) && (32'(w_along) < SIDE_XZ);
    assign w_vox_waddr    = {XW'(i_pos_x), YW'(i_pos_y), XW'(i_pos_z)};
    assign w_brd_waddr    = {i_border_side, YW'(i_pos_y), XW'(w_along)};

    assign w_rd_nbr    = nbr_of(i_cmd.rd_side, r_cur_x, r_cur_y, r_cur_z, i_neighbor_present);
    assign w_ev_nbr    = nbr_of(i_cmd.side, r_cur_x, r_cur_y, r_cur_z, i_neighbor_present);
    assign w_vox_raddr = i_cmd.rd_center ? {r_cur_x, r_cur_y, r_cur_z} : w_rd_nbr.vaddr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_voxel && w_vox_in_range) begin
            r_vox_mem[w_vox_waddr] <= i_block_id;
        end
        r_vox_rd <= r_vox_mem[w_vox_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_border && w_brd_in_range) begin
            r_brd_mem[w_brd_waddr] <= (i_block_id != '0);
        end
        r_brd_rd <= r_brd_mem[w_rd_nbr.baddr];
    end

    assign o_status.center_empty = (r_vox_rd == '0);

    always_comb begin
        case (w_ev_nbr.kind)
            NBR_OPEN:   w_vis = 1'b1;
            NBR_VOXEL:  w_vis = (r_vox_rd == '0);
            NBR_BORDER: w_vis = !r_brd_rd;
            default:    w_vis = 1'b1;
        endcase
    end

    assign w_done = (r_cur_x == XZ_MAX) && (r_cur_y == Y_MAX) && (r_cur_z == XZ_MAX);

    // A visible face is parked until the next one shows up, so the last
    // record of a step can carry its end mark.
    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_cur_z      = r_cur_z;
        n_face_total = r_face_total;
        n_pend_valid = r_pend_valid;
        n_pend_side  = r_pend_side;
        n_pend_index = r_pend_index;
        w_emit       = 1'b0;
        w_emit_valid = 1'b1;
        w_emit_side  = r_pend_side;
        w_emit_index = r_pend_index;
        w_emit_last  = 1'b0;
        if (i_cmd.latch_center) begin
            n_pend_valid = 1'b0;
        end
        if (i_cmd.eval && w_vis) begin
            w_emit       = r_pend_valid;
            n_pend_valid = 1'b1;
            n_pend_side  = i_cmd.side;
            n_pend_index = r_face_total;
            n_face_total = IDX_W'(r_face_total + 1'b1);
        end
        if (i_cmd.finish) begin
            w_emit       = 1'b1;
            w_emit_last  = 1'b1;
            n_pend_valid = 1'b0;
            if (!r_pend_valid) begin
                w_emit_valid = 1'b0;
                w_emit_side  = SIDE_SOUTH;
                w_emit_index = r_face_total;
            end
            if (w_done) begin
                n_cur_x      = '0;
                n_cur_y      = '0;
                n_cur_z      = '0;
                n_face_total = '0;
            end else if (r_cur_z != XZ_MAX) begin
                n_cur_z = XW'(r_cur_z + 1'b1);
            end else if (r_cur_y != Y_MAX) begin
                n_cur_z = '0;
                n_cur_y = YW'(r_cur_y + 1'b1);
            end else begin
                n_cur_z = '0;
                n_cur_y = '0;
                n_cur_x = XW'(r_cur_x + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_cur_z      <= '0;
            r_face_total <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_cur_z      <= n_cur_z;
            r_face_total <= n_face_total;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_side  <= n_pend_side;
        r_pend_index <= n_pend_index;
        if (i_cmd.latch_center) begin
            r_blk <= r_vox_rd;
        end
        if (w_emit) begin
            r_face_valid <= w_emit_valid;
            r_face_x     <= r_cur_x;
            r_face_y     <= r_cur_y;
            r_face_z     <= r_cur_z;
            r_face_side  <= w_emit_side;
            r_face_block <= r_blk;
            r_face_index <= w_emit_index;
            r_voxel_last <= w_emit_last;
            r_chunk_done <= w_done;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_face_valid = r_face_valid;
    assign o_face_x     = POS_XZ_W'(r_face_x);
    assign o_face_y     = POS_Y_W'(r_face_y);
    assign o_face_z     = POS_XZ_W'(r_face_z);
    assign o_face_side  = r_face_side;
    assign o_face_block = r_face_block;
    assign o_face_index = r_face_index;
    assign o_voxel_last = r_voxel_last;
    assign o_chunk_done = r_chunk_done;

    a_step_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_strobe && r_voxel_last)
        else $error("scan step ended without a closing record");

    a_last_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && r_voxel_last |-> $past(i_cmd.finish))
        else $error("end mark on a record not produced at step end");

    a_invalid_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_face_valid |-> r_voxel_last)
        else $error("invalid record that is not the only record of its step");

    a_chunk_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && w_done |=> r_face_total == '0 && r_cur_x == '0 && r_cur_z == '0)
        else $error("face count or cursor not cleared after final voxel");

endmodule

### hw/rtl/voxel_chunk_face_culler.sv
// Channel   Handshake            Payload
// command   start / busy         i_action, i_pos_x, i_pos_y, i_pos_z, i_block_id, i_border_side
// result    o_strobe (no stall)  o_face_valid .. o_chunk_done, one beat per strobe cycle
// config    APB psel/penable     paddr, pwdata, prdata, pready (always high)
//
// A load beat is taken at once and the block stays free to take the next beat.
// A scan beat keeps busy high while the block latches the voxel, reads its six neighbors
// from the voxel store, one read per cycle, and judges each face, then closes the step;
// an empty voxel skips its neighbors. No new beat is taken until busy falls.
// Each visible face is held until the next visible face is judged or the step closes,
// and its beat appears in the cycle after that; the last beat of a step shows in the
// cycle busy falls. Reset is synchronous, active low, and clears the scan cursor,
// face count and the neighbor register; the stores are not cleared. The receiver
// cannot stall, so nothing here waits on the result side.
module voxel_chunk_face_culler import vcfc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [ACT_W-1:0]    i_action,
    input  logic [POS_XZ_W-1:0] i_pos_x,
    input  logic [POS_Y_W-1:0]  i_pos_y,
    input  logic [POS_XZ_W-1:0] i_pos_z,
    input  logic [BLK_W-1:0]    i_block_id,
    input  logic [BSIDE_W-1:0]  i_border_side,
    output logic                o_strobe,
    output logic                o_face_valid,
    output logic [POS_XZ_W-1:0] o_face_x,
    output logic [POS_Y_W-1:0]  o_face_y,
    output logic [POS_XZ_W-1:0] o_face_z,
    output logic [SIDE_W-1:0]   o_face_side,
    output logic [BLK_W-1:0]    o_face_block,
    output logic [IDX_W-1:0]    o_face_index,
    output logic                o_voxel_last,
    output logic                o_chunk_done,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // Single configuration register: one presence bit per side neighbor chunk.
    // Bit order is north, south, west, east, matching the border plane codes.
    logic [NP_W-1:0] r_neighbor_present;
    logic            w_cfg_wr;

    t_cmd    w_cmd;
    t_status w_status;

    // The register index sits in paddr[2]; the low address bits are the byte lane.
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_present <= '0;
        end else if (w_cfg_wr && (paddr[2] == REG_NEIGHBOR_PRESENT)) begin
            r_neighbor_present <= pwdata[NP_W-1:0];
        end
    end

    // Reads return the register; the unused slot reads as zero.
    assign prdata = (paddr[2] == REG_NEIGHBOR_PRESENT) ? PDATA_W'(r_neighbor_present) : '0;
    assign pready = 1'b1;

    // The controller walks a scan step through its read slots and tells the
    // datapath which neighbor to fetch and which face to judge in each cycle.
    vcfc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    // The datapath owns both stores, the scan cursor, the running face count
    // and the result registers.
    vcfc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_neighbor_present (r_neighbor_present),
        .i_pos_x            (i_pos_x),
        .i_pos_y            (i_pos_y),
        .i_pos_z            (i_pos_z),
        .i_block_id         (i_block_id),
        .i_border_side      (i_border_side),
        .o_strobe           (o_strobe),
        .o_face_valid       (o_face_valid),
        .o_face_x           (o_face_x),
        .o_face_y           (o_face_y),
        .o_face_z           (o_face_z),
        .o_face_side        (o_face_side),
        .o_face_block       (o_face_block),
        .o_face_index       (o_face_index),
        .o_voxel_last       (o_voxel_last),
        .o_chunk_done       (o_chunk_done)
    );

endmodule

### tb/sv/voxel_chunk_face_culler_tb.sv
`timescale 1ns / 100ps

module voxel_chunk_face_culler_tb import vcfc_pkg::*;;

    // Action code that the block must ignore without producing a beat.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    // Byte address of the neighbor_present register.
    localparam logic [PADDR_W-1:0] NEIGHBOR_ADDR = {REG_NEIGHBOR_PRESENT, 2'b00};

    localparam int FACES        = 6;
    localparam int MAX_GAP      = 40;    // longest sender pause, in cycles
    localparam int SETTLE       = 16;    // long enough to cover the tail of a scan
    localparam int STALL_LIMIT  = 1000;  // cycles without any beat or register access before giving up
    localparam int REPORT_LIMIT = 10;
    // Scans stay within the first rows of the x = 0 slice, whose cells and
    // neighbors are all loaded before the first scan.
    localparam int SCAN_ROWS    = 3;
    localparam int SCAN_LIMIT   = SCAN_ROWS * SIDE_XZ;

    // One result beat, in the order of the result ports.
    typedef struct packed {
        logic                valid;
        logic [POS_XZ_W-1:0] x;
        logic [POS_Y_W-1:0]  y;
        logic [POS_XZ_W-1:0] z;
        t_side               side;
        logic [BLK_W-1:0]    blk;
        logic [IDX_W-1:0]    index;
        logic                last;
        logic                done;
    } t_face_rec;

    // The scoreboard keeps its own copy of the chunk, the border planes, the scan
    // cursor and the face count, predicts the beats of every accepted command and
    // checks each result beat against the oldest prediction.
    class t_cull_predictor;
        logic [BLK_W-1:0] block_ids [VOX_DEPTH];
        bit               plane_solid [BRD_DEPTH];
        logic [VAW-1:0]   scan_pos;
        logic [IDX_W-1:0] faces_so_far;
        logic [NP_W-1:0]  neighbors;
        t_face_rec        pending_faces [$];
        int mismatches, faces_seen, blanks_seen, loads, scans;

        function new();
            scan_pos     = '0;
            faces_so_far = '0;
            neighbors    = '0;
        endfunction

        function bit is_air(logic [XW-1:0] x, logic [YW-1:0] y, logic [XW-1:0] z);
            return block_ids[{x, y, z}] == '0;
        endfunction

        // A side face on the chunk edge is open unless the neighbor chunk is
        // present and its border cell is solid.
        function bit edge_open(t_border b, logic [YW-1:0] y, logic [XW-1:0] along);
            if (!neighbors[b])
                return 1'b1;
            return !plane_solid[{b, y, along}];
        endfunction

        function void scan_voxel();
            logic [XW-1:0]    x, z;
            logic [YW-1:0]    y;
            logic [BLK_W-1:0] blk;
            bit               open [FACES];
            bit               done;
            int               n;
            {x, y, z} = scan_pos;
            blk  = block_ids[scan_pos];
            done = (x == XZ_MAX) && (y == Y_MAX) && (z == XZ_MAX);
            open = '{default: 1'b0};
            n    = 0;
            if (blk != '0) begin
                open[SIDE_SOUTH] = (z == 0) ? edge_open(BRD_SOUTH, y, x)
                                            : is_air(x, y, z - 1'b1);
                open[SIDE_EAST]  = (x == XZ_MAX) ? edge_open(BRD_EAST, y, z)
                                                 : is_air(x + 1'b1, y, z);
                open[SIDE_NORTH] = (z == XZ_MAX) ? edge_open(BRD_NORTH, y, x)
                                                 : is_air(x, y, z + 1'b1);
                open[SIDE_WEST]  = (x == 0) ? edge_open(BRD_WEST, y, z)
                                            : is_air(x - 1'b1, y, z);
                open[SIDE_UP]    = (y == Y_MAX) || is_air(x, y + 1'b1, z);
                open[SIDE_DOWN]  = (y == 0) || is_air(x, y - 1'b1, z);
            end
            for (int s = 0; s < FACES; s++) begin
                if (open[s]) begin
                    pending_faces.push_back('{1'b1, x, y, z, t_side'(s), blk, faces_so_far,
                                              1'b0, done});
                    faces_so_far = faces_so_far + 1'b1;
                    n++;
                end
            end
            if (n == 0)
                pending_faces.push_back('{1'b0, x, y, z, SIDE_SOUTH, blk, faces_so_far,
                                          1'b0, done});
            pending_faces[$].last = 1'b1;
            if (done) begin
                scan_pos     = '0;
                faces_so_far = '0;
            end else begin
                scan_pos = scan_pos + 1'b1;
            end
        endfunction

        function void take_command(logic [ACT_W-1:0] act, logic [POS_XZ_W-1:0] px,
                                   logic [POS_Y_W-1:0] py, logic [POS_XZ_W-1:0] pz,
                                   logic [BLK_W-1:0] bid, logic [BSIDE_W-1:0] bside);
            logic [XW-1:0] along;
            case (act)
                ACT_LOAD_VOXEL: begin
                    loads++;
                    if (px <= XZ_MAX && py <= Y_MAX && pz <= XZ_MAX)
                        block_ids[{px, py, pz}] = bid;
                end
                ACT_LOAD_BORDER: begin
                    loads++;
                    along = (bside == BRD_NORTH || bside == BRD_SOUTH) ? px : pz;
                    if (py <= Y_MAX && along <= XZ_MAX)
                        plane_solid[{bside, py, along}] = (bid != '0);
                end
                ACT_SCAN: begin
                    scans++;
                    scan_voxel();
                end
                default: ;
            endcase
        endfunction

        function string show(t_face_rec r);
            return $sformatf({"valid=%0d x=%0d y=%0d z=%0d side=%0d blk=%h idx=%0d",
                              " last=%0d done=%0d"},
                             r.valid, r.x, r.y, r.z, r.side, r.blk, r.index, r.last, r.done);
        endfunction

        function void check_face(t_face_rec got);
            t_face_rec want;
            if (pending_faces.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result beat with nothing pending: %s", $time, show(got));
                return;
            end
            want = pending_faces.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: face mismatch", $time);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end else if (got.valid) begin
                faces_seen++;
            end else begin
                blanks_seen++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ACT_W-1:0]    i_action = ACT_LOAD_VOXEL;
    logic [POS_XZ_W-1:0] i_pos_x = '0;
    logic [POS_Y_W-1:0]  i_pos_y = '0;
    logic [POS_XZ_W-1:0] i_pos_z = '0;
    logic [BLK_W-1:0]    i_block_id = '0;
    logic [BSIDE_W-1:0]  i_border_side = '0;
    logic                o_strobe;
    logic                o_face_valid;
    logic [POS_XZ_W-1:0] o_face_x;
    logic [POS_Y_W-1:0]  o_face_y;
    logic [POS_XZ_W-1:0] o_face_z;
    logic [SIDE_W-1:0]   o_face_side;
    logic [BLK_W-1:0]    o_face_block;
    logic [IDX_W-1:0]    o_face_index;
    logic                o_voxel_last;
    logic                o_chunk_done;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    t_cull_predictor model = new();
    int sender_idle_pct = 0;   // chance per cycle that the sender holds back a beat
    int reg_errors = 0;
    int stall_cycles = 0;
    logic [NP_W-1:0] last_mask;

    voxel_chunk_face_culler dut (.*);

    // 10 ns clock, first rising edge at 5 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result beats cannot be held off, so every strobe cycle is one beat. The
    // outputs are read at the edge that ends the cycle, i.e. their settled values.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            model.check_face('{o_face_valid, o_face_x, o_face_y, o_face_z, t_side'(o_face_side),
                               o_face_block, o_face_index, o_voxel_last, o_chunk_done});
    end

    // Watchdog: any command beat, result beat or register access counts as
    // progress. A long stretch with none of them means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1 || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d beats still pending",
                     $time, STALL_LIMIT, model.pending_faces.size());
            $display("voxel_chunk_face_culler_tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Random block id; air_pct is the chance of an empty voxel. The two extreme
    // ids turn up often so that every bit of the field toggles.
    function automatic logic [BLK_W-1:0] pick_block(input int air_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < air_pct)
            return '0;
        roll = $urandom_range(9);
        if (roll == 0)
            return '1;
        if (roll == 1)
            return BLK_W'(1);
        return BLK_W'($urandom_range(1, (1 << BLK_W) - 1));
    endfunction

    // Presents one command beat and returns at the edge where it is taken, that
    // is, the first edge with start high and busy low. Start is left high, so a
    // caller that does not follow with another beat must lower it itself.
    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [POS_XZ_W-1:0] px,
                            input logic [POS_Y_W-1:0] py, input logic [POS_XZ_W-1:0] pz,
                            input logic [BLK_W-1:0] bid, input logic [BSIDE_W-1:0] bside);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_pos_x       <= px;
        i_pos_y       <= py;
        i_pos_z       <= pz;
        i_block_id    <= bid;
        i_border_side <= bside;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        model.take_command(act, px, py, pz, bid, bside);
    endtask

    // A scan beat with junk in the fields that a scan ignores.
    task automatic scan_once();
        send_cmd(ACT_SCAN, POS_XZ_W'($urandom), POS_Y_W'($urandom), POS_XZ_W'($urandom),
                 BLK_W'($urandom), BSIDE_W'($urandom));
    endtask

    // Stops sending and waits until every predicted beat has come and the block
    // is idle, then lets a few more cycles pass for anything that trails.
    task automatic drain();
        start <= 1'b0;
        while (model.pending_faces.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Writes neighbor_present with junk in the unused upper bits, then reads it
    // back. Only done with the block drained.
    task automatic set_neighbors(input logic [NP_W-1:0] mask);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NEIGHBOR_ADDR;
        pwdata  <= {(PDATA_W - NP_W)'($urandom), mask};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        model.neighbors = mask;
        last_mask = mask;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[NP_W-1:0] !== mask) begin
            reg_errors++;
            $display("%0t: neighbor_present reads %h, wrote %h", $time, prdata[NP_W-1:0], mask);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Fills every cell that a scan of the first SCAN_ROWS rows of the x = 0
    // slice can look at: those rows and the row above them, the same rows of
    // the x = 1 slice, the west plane along those rows and the south and north
    // border cells at x = 0. Air grows with height, which gives exposed faces,
    // buried voxels and empty cells.
    task automatic load_chunk();
        int air_pct;
        for (int x = 0; x < 2; x++) begin
            for (int y = 0; y < SCAN_ROWS + 1 - x; y++) begin
                air_pct = 20 + 20 * y;
                for (int z = 0; z < SIDE_XZ; z++)
                    send_cmd(ACT_LOAD_VOXEL, POS_XZ_W'(x), POS_Y_W'(y), POS_XZ_W'(z),
                             pick_block(air_pct), BSIDE_W'($urandom));
            end
        end
        for (int y = 0; y < SCAN_ROWS; y++) begin
            send_cmd(ACT_LOAD_BORDER, '0, POS_Y_W'(y), POS_XZ_W'($urandom),
                     pick_block(50), BRD_SOUTH);
            send_cmd(ACT_LOAD_BORDER, '0, POS_Y_W'(y), POS_XZ_W'($urandom),
                     pick_block(50), BRD_NORTH);
            for (int a = 0; a < SIDE_XZ; a++)
                send_cmd(ACT_LOAD_BORDER, POS_XZ_W'($urandom), POS_Y_W'(y), POS_XZ_W'(a),
                         pick_block(50), BRD_WEST);
        end
    endtask

    // Random traffic. Most loads land on voxels just ahead of the scan cursor
    // or on their neighbors, so the scans that follow see freshly changed
    // surroundings. The rest are scans, loads anywhere and ignored actions.
    // Scans stop once the cursor leaves the loaded rows.
    task automatic random_items(input int count);
        logic [VAW-1:0] spot;
        logic [XW-1:0]  x, z;
        logic [YW-1:0]  y;
        int             roll;
        for (int i = 0; i < count; i++) begin
            // Now and then hold back until the block has caught up completely.
            if ($urandom_range(99) < 3)
                drain();
            spot = model.scan_pos + VAW'($urandom_range(24));
            {x, y, z} = spot;
            case ($urandom_range(5))
                0: x = x + 1'b1;
                1: x = x - 1'b1;
                2: z = z - 1'b1;
                3: y = y + 1'b1;
                default: ;
            endcase
            roll = $urandom_range(99);
            if (roll < 15 && model.scan_pos < SCAN_LIMIT)
                scan_once();
            else if (roll < 70)
                send_cmd(ACT_LOAD_VOXEL, x, y, z, pick_block(45), BSIDE_W'($urandom));
            else if (roll < 85)
                send_cmd(ACT_LOAD_BORDER, x, y, z, pick_block(50), t_border'($urandom_range(3)));
            else if (roll < 96)
                send_cmd(ACT_LOAD_VOXEL, POS_XZ_W'($urandom), POS_Y_W'($urandom),
                         POS_XZ_W'($urandom), pick_block(30), BSIDE_W'($urandom));
            else
                send_cmd(ACT_UNUSED, POS_XZ_W'($urandom), POS_Y_W'($urandom),
                         POS_XZ_W'($urandom), BLK_W'($urandom), BSIDE_W'($urandom));
        end
    endtask

    initial begin
        // Synchronous reset held from the start, released once.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // No neighbors while the chunk is loaded; loads never read the register.
        sender_idle_pct = 16;
        set_neighbors('0);
        load_chunk();

        // Directed beats with every neighbor present. The cursor is at the
        // corner voxel (0,0,0), which touches the south and west borders and
        // the floor.
        set_neighbors('1);
        send_cmd(ACT_UNUSED, '1, '1, '1, '1, BRD_EAST);
        send_cmd(ACT_LOAD_VOXEL, '0, '0, '0, '1, BRD_NORTH);
        send_cmd(ACT_LOAD_VOXEL, '0, '0, POS_XZ_W'(1), '0, BRD_NORTH);
        send_cmd(ACT_LOAD_VOXEL, POS_XZ_W'(1), '0, '0, BLK_W'(1), BRD_NORTH);
        send_cmd(ACT_LOAD_VOXEL, '0, POS_Y_W'(1), '0, BLK_W'(16'h8000), BRD_NORTH);
        // Solid south border cell hides the south face; open west border shows
        // the west face.
        send_cmd(ACT_LOAD_BORDER, '0, '0, '1, '1, BRD_SOUTH);
        send_cmd(ACT_LOAD_BORDER, '1, '0, '0, '0, BRD_WEST);
        // Corner voxel: north, west and down open; south, east and up hidden.
        scan_once();
        // Empty voxel: a single blank beat carrying the running count.
        scan_once();
        send_cmd(ACT_UNUSED, '0, '0, '0, '0, BRD_NORTH);
        scan_once();

        // Random traffic under three sender behaviors and neighbor masks.
        random_items(80);
        set_neighbors(4'b0101);
        sender_idle_pct = 83;
        random_items(75);
        set_neighbors(4'b1010);
        sender_idle_pct = 0;
        random_items(75);

        // Scan on through the rest of the loaded rows.
        set_neighbors(NP_W'($urandom));
        while (model.scan_pos < SCAN_LIMIT)
            scan_once();

        drain();
        $display("covered %0d load beats and %0d scan beats: %0d face beats, %0d blank beats",
                 model.loads, model.scans, model.faces_seen, model.blanks_seen);
        $display("neighbor masks 0, f, 5, a and %h; %0d mismatches",
                 last_mask, model.mismatches + reg_errors);
        if (model.mismatches == 0 && reg_errors == 0) begin
            $display("voxel_chunk_face_culler_tb: clean");
        end else begin
            $display("voxel_chunk_face_culler_tb: errors");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/vcfc_pkg.sv
hw/rtl/vcfc_ctrl.sv
hw/rtl/vcfc_datapath.sv
hw/rtl/voxel_chunk_face_culler.sv
tb/sv/voxel_chunk_face_culler_tb.sv
